### design/pssm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pssm_pkg: shared types and constants of the scoring matrix scanner
// Field widths, matrix geometry, command codes and the control bundle
// that the scanner broadcasts to its column cells.
// ----------------------------------------------------------------------------
package pssm_pkg;

    // Matrix geometry.
    localparam int MAX_WIDTH     = 64;
    localparam int ALPHABET_SIZE = 20;
    localparam int MAX_ROW_LEN   = 65536;
    localparam int WIDX_W        = $clog2(MAX_WIDTH);

    // Field widths.
    localparam int COL_W     = 6;
    localparam int RES_W     = 5;
    localparam int SCORE_W   = 16;
    localparam int SUM_W     = 24;
    localparam int POS_W     = 16;
    localparam int WIDTH_W   = 7;

    // Configuration port.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 24;

    localparam logic [POS_W-1:0]   ROW_POS_MAX = POS_W'(MAX_ROW_LEN - 1);
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(8);

    // Item command codes.
    typedef enum logic {
        FUNC_WRITE   = 1'b0,
        FUNC_RESIDUE = 1'b1
    } func_t;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_WINDOW_WIDTH  = 2'd0,
        CFG_HIT_THRESHOLD = 2'd1
    } cfg_reg_t;

    // Control broadcast from the scanner to every column cell.
    typedef struct packed {
        logic                       wr_en;
        logic [COL_W-1:0]           wr_col;
        logic [RES_W-1:0]           wr_res;
        logic signed [SCORE_W-1:0]  wr_score;
        logic                       rd_en;
        logic [RES_W-1:0]           rd_res;
        logic                       acc_en;
    } cell_ctrl_t;

    // Per-request bookkeeping that travels beside the cell chain.
    typedef struct packed {
        logic             full_window;
        logic [POS_W-1:0] start;
        logic             row_end;
    } pipe_info_t;

endpackage : pssm_pkg
`default_nettype wire

### design/pssm_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pssm_if: handshake channels of the scoring matrix scanner
// Input request channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------
interface pssm_in_if import pssm_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      func;
    logic [COL_W-1:0]          column;
    logic [RES_W-1:0]          residue;
    logic signed [SCORE_W-1:0] score;
    logic                      row_end;

    modport source (output valid, func, column, residue, score, row_end, input ready);
    modport sink   (input valid, func, column, residue, score, row_end, output ready);
endinterface : pssm_in_if

interface pssm_out_if import pssm_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    window_valid;
    logic signed [SUM_W-1:0] window_score;
    logic                    hit;
    logic [POS_W-1:0]        window_start;
    logic signed [SUM_W-1:0] row_max;
    logic                    row_done;

    modport source (output valid, window_valid, window_score, hit, window_start,
                    row_max, row_done, input ready);
    modport sink   (input valid, window_valid, window_score, hit, window_start,
                    row_max, row_done, output ready);
endinterface : pssm_out_if

interface pssm_cfg_if import pssm_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface : pssm_cfg_if
`default_nettype wire

### design/pssm_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pssm_cell: one matrix column of the scanning chain
// Holds the scores of its column for every amino acid, looks up the score
// of the broadcast residue and adds it to the partial sum handed in by the
// previous column, passing the result on to the next column.
// ----------------------------------------------------------------------------
module pssm_cell import pssm_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic [COL_W-1:0]        col_id,
    input  wire cell_ctrl_t              ctrl,
    input  wire logic signed [SUM_W-1:0] acc_in,
    output logic signed [SUM_W-1:0]      acc_out
);

    logic signed [SCORE_W-1:0] mem [ALPHABET_SIZE];
    logic signed [SCORE_W-1:0] rd_reg;
    logic signed [SUM_W-1:0]   acc_reg;

    // Table write: only this column, only real amino acids.
    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en && (ctrl.wr_col == col_id) &&
            (ctrl.wr_res < RES_W'(ALPHABET_SIZE)))
        begin
            mem[ctrl.wr_res] <= ctrl.wr_score;
        end
    end

    // Score lookup; a residue code outside the alphabet scores zero.
    always_ff @(posedge clk)
    begin
        if (ctrl.rd_en)
        begin
            if (ctrl.rd_res < RES_W'(ALPHABET_SIZE))
            begin
                rd_reg <= mem[ctrl.rd_res];
            end
            else
            begin
                rd_reg <= '0;
            end
        end
    end

    // Partial window sum. Even a full window of extreme scores stays well
    // inside the 24-bit range, so the sum cannot overflow.
    always_ff @(posedge clk)
    begin
        if (ctrl.acc_en)
        begin
            acc_reg <= acc_in + {{(SUM_W-SCORE_W){rd_reg[SCORE_W-1]}}, rd_reg};
        end
    end

    assign acc_out = acc_reg;

endmodule : pssm_cell
`default_nettype wire

### design/pssm_window_scan.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pssm_window_scan: position scoring matrix scan over a residue stream
// A residue request's result passes the score lookup in the cells, the chain add
//   and the result register.
// One residue request per cycle while the result channel takes results and no
//   replay runs. A table write gives no result and holds the input off while the chain is rebuilt.
// Reset clears the pipeline, residue history, row position and row maximum and
//   restores the configuration defaults; the score table is undefined until written.
// ----------------------------------------------------------------------------
module pssm_window_scan import pssm_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    pssm_in_if.sink    item,
    pssm_out_if.source result,
    pssm_cfg_if.sink   cfg
);

    logic [WIDTH_W-1:0]      width_reg;
    logic signed [SUM_W-1:0] thr_reg;
    logic [POS_W-1:0]        row_pos_reg, row_pos_next;
    logic signed [SUM_W-1:0] best_reg, best_next;

    logic       b_valid_reg, c_valid_reg, out_valid_reg;
    logic       b_step_reg;
    pipe_info_t a_info, b_info_reg, c_info_reg;

    logic                    out_window_valid_reg;
    logic signed [SUM_W-1:0] out_window_score_reg;
    logic                    out_hit_reg;
    logic [POS_W-1:0]        out_window_start_reg;
    logic signed [SUM_W-1:0] out_row_max_reg;
    logic                    out_row_done_reg;

    logic [RES_W-1:0]        hist_reg [MAX_WIDTH];
    logic                    replay_reg;
    logic [WIDX_W-1:0]       replay_cnt_reg;

    logic [WIDTH_W-1:0]      eff_w;
    logic [WIDTH_W-1:0]      w_minus1;
    logic [WIDX_W-1:0]       w_idx;
    logic                    adv, accept, res_acc, wr_acc;
    logic                    replay_step, chain_step;
    cell_ctrl_t              ctrl;
    logic signed [SUM_W-1:0] acc_chain [MAX_WIDTH];
    logic signed [SUM_W-1:0] win_sum;
    logic signed [SUM_W-1:0] best_cand;

    // Configuration writes.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= WIDTH_RESET;
            thr_reg   <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_WINDOW_WIDTH:  width_reg <= cfg.data[WIDTH_W-1:0];
                CFG_HIT_THRESHOLD: thr_reg   <= cfg.data[SUM_W-1:0];
                default:           ;
            endcase
        end
    end

    // Effective window width: zero acts as one, large values clamp.
    always_comb
    begin
        if (width_reg == '0)
        begin
            eff_w = WIDTH_W'(1);
        end
        else if (width_reg > WIDTH_W'(MAX_WIDTH))
        begin
            eff_w = WIDTH_W'(MAX_WIDTH);
        end
        else
        begin
            eff_w = width_reg;
        end
        w_minus1 = eff_w - WIDTH_W'(1);
        w_idx    = w_minus1[WIDX_W-1:0];
    end

    // Handshake: the whole pipeline moves when the result register is free.
    // The input waits while the chain is being rebuilt after a table write.
    assign adv         = !out_valid_reg || result.ready;
    assign item.ready  = adv && !replay_reg;
    assign accept      = item.valid && item.ready;
    assign res_acc     = accept && (item.func == FUNC_RESIDUE);
    assign wr_acc      = accept && (item.func == FUNC_WRITE);
    assign replay_step = replay_reg && adv;
    assign chain_step  = res_acc || replay_step;

    // Broadcast control to the column cells.
    always_comb
    begin
        ctrl.wr_en    = wr_acc;
        ctrl.wr_col   = item.column;
        ctrl.wr_res   = item.residue;
        ctrl.wr_score = item.score;
        ctrl.rd_en    = chain_step;
        ctrl.rd_res   = replay_reg ? hist_reg[MAX_WIDTH-1] : item.residue;
        ctrl.acc_en   = adv && b_step_reg;
    end

    // A table write is followed by a replay of the residue history, oldest
    // first, so that every partial sum in the chain uses the new table.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            replay_reg     <= 1'b0;
            replay_cnt_reg <= '0;
        end
        else if (wr_acc)
        begin
            replay_reg     <= 1'b1;
            replay_cnt_reg <= '0;
        end
        else if (replay_step)
        begin
            if (replay_cnt_reg == WIDX_W'(MAX_WIDTH - 1))
            begin
                replay_reg <= 1'b0;
            end
            replay_cnt_reg <= replay_cnt_reg + WIDX_W'(1);
        end
    end

    // Residue history, newest at index 0. A replay step rotates it once, so
    // a full replay leaves it as it was.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_WIDTH; k++)
            begin
                hist_reg[k] <= '0;
            end
        end
        else if (chain_step)
        begin
            hist_reg[0] <= replay_reg ? hist_reg[MAX_WIDTH-1] : item.residue;
            for (int k = 1; k < MAX_WIDTH; k++)
            begin
                hist_reg[k] <= hist_reg[k-1];
            end
        end
    end

    // Column chain: cell c adds column c's score to the sum from cell c-1.
    for (genvar c = 0; c < MAX_WIDTH; c++)
    begin : g_cell
        logic signed [SUM_W-1:0] chain_in;
        if (c == 0)
        begin : g_head
            assign chain_in = '0;
        end
        else
        begin : g_link
            assign chain_in = acc_chain[c-1];
        end
        pssm_cell u_cell (
            .clk     (clk),
            .col_id  (COL_W'(c)),
            .ctrl    (ctrl),
            .acc_in  (chain_in),
            .acc_out (acc_chain[c])
        );
    end

    // Row bookkeeping at acceptance of a residue.
    always_comb
    begin
        a_info.full_window = ({1'b0, row_pos_reg} + (POS_W+1)'(1)) >=
                             (POS_W+1)'(eff_w);
        a_info.start       = a_info.full_window ?
                             (row_pos_reg - POS_W'(w_minus1)) : '0;
        a_info.row_end     = item.row_end;

        if (item.row_end)
        begin
            row_pos_next = '0;
        end
        else if (row_pos_reg < ROW_POS_MAX)
        begin
            row_pos_next = row_pos_reg + POS_W'(1);
        end
        else
        begin
            row_pos_next = row_pos_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_pos_reg <= '0;
        end
        else if (res_acc)
        begin
            row_pos_reg <= row_pos_next;
        end
    end

    // Pipeline valid flags; a chain step is a residue or a replay step.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg   <= 1'b0;
            b_step_reg    <= 1'b0;
            c_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            b_valid_reg   <= res_acc;
            b_step_reg    <= chain_step;
            c_valid_reg   <= b_valid_reg;
            out_valid_reg <= c_valid_reg;
        end
    end

    // Bookkeeping that travels beside the chain.
    always_ff @(posedge clk)
    begin
        if (res_acc)
        begin
            b_info_reg <= a_info;
        end
        if (adv && b_valid_reg)
        begin
            c_info_reg <= b_info_reg;
        end
    end

    // Window sum and running row maximum.
    always_comb
    begin
        win_sum = acc_chain[w_idx];
        if (c_info_reg.full_window && (win_sum > best_reg))
        begin
            best_cand = win_sum;
        end
        else
        begin
            best_cand = best_reg;
        end
        best_next = c_info_reg.row_end ? SUM_MIN : best_cand;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg <= SUM_MIN;
        end
        else if (adv && c_valid_reg)
        begin
            best_reg <= best_next;
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (adv && c_valid_reg)
        begin
            out_window_valid_reg <= c_info_reg.full_window;
            out_window_score_reg <= c_info_reg.full_window ? win_sum : '0;
            out_hit_reg          <= c_info_reg.full_window && (win_sum >= thr_reg);
            out_window_start_reg <= c_info_reg.start;
            out_row_max_reg      <= c_info_reg.row_end ? best_cand : '0;
            out_row_done_reg     <= c_info_reg.row_end;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.window_valid = out_window_valid_reg;
    assign result.window_score = out_window_score_reg;
    assign result.hit          = out_hit_reg;
    assign result.window_start = out_window_start_reg;
    assign result.row_max      = out_row_max_reg;
    assign result.row_done     = out_row_done_reg;

endmodule : pssm_window_scan
`default_nettype wire
